@@ rtl/arp_pkg.sv @@
package arp_pkg;

  localparam int MAC_W = 48;
  localparam int IP_W  = 32;
  localparam int TAG_W = 16;
  localparam int AGE_W = 8;

  localparam logic [MAC_W-1:0] BCAST_MAC  = {MAC_W{1'b1}};
  localparam logic [15:0]      HTYPE_ETH  = 16'h0001;
  localparam logic [15:0]      PTYPE_IPV4 = 16'h0800;
  localparam logic [15:0]      OPER_REQ   = 16'd1;
  localparam logic [15:0]      OPER_REPLY = 16'd2;
  localparam logic [10:0]      MIN_BODY   = 11'd8;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_ANSWER  = 2'd1,
    KIND_REQUEST = 2'd2,
    KIND_REPLY   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_LEN  = 3'd1,
    ST_BAD_TYPE = 3'd2,
    ST_BAD_OPER = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  localparam logic CFG_OWN_MAC  = 1'b0;
  localparam logic CFG_OWN_IPV4 = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CSCAN,
    S_DECIDE,
    S_EMIT_RESOLVE,
    S_EMIT_REPLY,
    S_PSCAN,
    S_EMIT_ANSWER,
    S_EMIT_FINAL
  } state_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [2:0]       status;
    logic [MAC_W-1:0] peer_mac;
    logic [IP_W-1:0]  peer_ip;
    logic [TAG_W-1:0] req_tag;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [MAC_W-1:0] dst;
    logic [MAC_W-1:0] src;
    logic [10:0]      body_len;
    logic [15:0]      hw_type;
    logic [15:0]      proto_type;
    logic [7:0]       hw_len;
    logic [7:0]       proto_len;
    logic [15:0]      oper_or_tag;
    logic [MAC_W-1:0] sender_mac;
    logic [IP_W-1:0]  sender_ip;
    logic [IP_W-1:0]  target_ip;
  } item_t;

  // Word travelling along a cell chain during a scan
  typedef struct packed {
    logic            act;
    logic [IP_W-1:0] key;
  } probe_t;

  // Cache chain commands
  typedef struct packed {
    logic             start;
    logic [IP_W-1:0]  key;
    logic             wr;
    logic             wr_new;
    logic [MAC_W-1:0] wr_mac;
  } cache_ctl_t;

  typedef struct packed {
    logic             done;
    logic             hit;
    logic [MAC_W-1:0] mac;
    logic             has_free;
  } cache_sts_t;

  typedef struct packed {
    logic             start;
    logic [IP_W-1:0]  key;
    logic             ins;
    logic [TAG_W-1:0] ins_tag;
    logic             rel;
  } pend_ctl_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [TAG_W-1:0] tag;
    logic             has_free;
  } pend_sts_t;

endpackage

@@ rtl/arp_if.sv @@
interface arp_in_if;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [47:0]       eth_dst_mac;
  logic [47:0]       eth_src_mac;
  logic [10:0]       body_len;
  logic [15:0]       hw_type;
  logic [15:0]       proto_type;
  logic [7:0]        hw_len;
  logic [7:0]        proto_len;
  logic [15:0]       oper_or_tag;
  logic [47:0]       sender_mac;
  logic [31:0]       sender_ip;
  logic [31:0]       target_ip;
  modport source (output valid, cmd, eth_dst_mac, eth_src_mac, body_len, hw_type,
                  proto_type, hw_len, proto_len, oper_or_tag, sender_mac,
                  sender_ip, target_ip, input ready);
  modport sink   (input valid, cmd, eth_dst_mac, eth_src_mac, body_len, hw_type,
                  proto_type, hw_len, proto_len, oper_or_tag, sender_mac,
                  sender_ip, target_ip, output ready);
endinterface

interface arp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  status;
  logic [47:0] peer_mac;
  logic [31:0] peer_ip;
  logic [15:0] req_tag;
  logic        last;
  modport source (output valid, kind, status, peer_mac, peer_ip, req_tag, last,
                  input ready);
  modport sink   (input valid, kind, status, peer_mac, peer_ip, req_tag, last,
                  output ready);
endinterface

interface arp_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/arp_cache_cell.sv @@
// One cache entry. A probe word walks the chain; the first valid entry
// whose address matches claims it and stops it there.
module arp_cache_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  arp_pkg::probe_t           probe_in,
  output arp_pkg::probe_t           probe_out,
  input  logic                      free_in,
  output logic                      free_out,
  input  logic                      clear_hit,
  input  logic                      wr,
  input  logic                      wr_new,
  input  logic [arp_pkg::MAC_W-1:0] wr_mac,
  input  logic [arp_pkg::IP_W-1:0]  wr_ip,
  output logic                      hit,
  output logic [arp_pkg::MAC_W-1:0] mac
);
  logic                      valid_r, valid_nxt;
  logic                      hit_r, hit_nxt;
  logic [arp_pkg::IP_W-1:0]  ip_r;
  logic [arp_pkg::MAC_W-1:0] mac_r;
  logic                      match;
  logic                      claim_free;

  assign match = probe_in.act && valid_r && ip_r == probe_in.key;
  // first free cell takes a new entry
  assign claim_free = wr && wr_new && !valid_r && !free_in;
  assign free_out = free_in || !valid_r;

  // pass probe on unless claimed here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_out.act <= 1'b0;
    end else begin
      probe_out.act <= probe_in.act && !match;
    end
    probe_out.key <= probe_in.key;
  end

  always_comb begin
    valid_nxt = valid_r;
    hit_nxt   = hit_r;
    if (clear_hit) begin
      hit_nxt = 1'b0;
    end
    if (match) begin
      hit_nxt = 1'b1;
    end
    if (claim_free) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      hit_r   <= hit_nxt;
    end
  end

  // payload update on hit or allocation
  always_ff @(posedge clk) begin
    if (claim_free) begin
      ip_r  <= wr_ip;
      mac_r <= wr_mac;
    end else if (wr && !wr_new && hit_r) begin
      mac_r <= wr_mac;
    end
  end

  assign hit = hit_r;
  assign mac = mac_r;
endmodule

@@ rtl/arp_pend_cell.sv @@
// One pending request. A probe walks the chain; every matching entry
// offers its age, and the youngest match is the one released.
module arp_pend_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  arp_pkg::probe_t           probe_in,
  output arp_pkg::probe_t           probe_out,
  input  logic                      clear_hit,
  input  logic                      best_in,
  input  logic [arp_pkg::AGE_W-1:0] best_age_in,
  input  logic [arp_pkg::TAG_W-1:0] best_tag_in,
  output logic                      best_out,
  output logic [arp_pkg::AGE_W-1:0] best_age_out,
  output logic [arp_pkg::TAG_W-1:0] best_tag_out,
  input  logic                      free_in,
  output logic                      free_out,
  input  logic                      ins,
  input  logic [arp_pkg::IP_W-1:0]  ins_ip,
  input  logic [arp_pkg::TAG_W-1:0] ins_tag,
  input  logic                      rel,
  input  logic [arp_pkg::AGE_W-1:0] rel_age
);
  logic                      valid_r, valid_nxt;
  logic                      match_r, match_nxt;
  logic [arp_pkg::IP_W-1:0]  ip_r;
  logic [arp_pkg::TAG_W-1:0] tag_r;
  logic [arp_pkg::AGE_W-1:0] age_r, age_nxt;
  logic                      take;
  logic                      claim;
  logic                      mine;

  assign take = match_r && (!best_in || age_r < best_age_in);
  assign best_out     = best_in || match_r;
  assign best_age_out = take ? age_r : best_age_in;
  assign best_tag_out = take ? tag_r : best_tag_in;
  assign free_out = free_in || !valid_r;
  assign claim = ins && !valid_r && !free_in;
  assign mine  = rel && valid_r && match_r && age_r == rel_age;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_out.act <= 1'b0;
    end else begin
      probe_out.act <= probe_in.act;
    end
    probe_out.key <= probe_in.key;
  end

  always_comb begin
    valid_nxt = valid_r;
    match_nxt = match_r;
    age_nxt   = age_r;
    if (clear_hit) begin
      match_nxt = 1'b0;
    end
    if (probe_in.act && valid_r && ip_r == probe_in.key) begin
      match_nxt = 1'b1;
    end
    if (ins && valid_r && age_r != '1) begin
      age_nxt = age_r + 1'b1;
    end
    if (claim) begin
      valid_nxt = 1'b1;
      age_nxt   = '0;
    end
    if (rel && valid_r && age_r > rel_age) begin
      age_nxt = age_r - 1'b1;
    end
    if (mine) begin
      valid_nxt = 1'b0;
      match_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    age_r <= age_nxt;
    if (claim) begin
      ip_r  <= ins_ip;
      tag_r <= ins_tag;
    end
  end
endmodule

@@ rtl/arp_cache_chain.sv @@
// Row of cache cells with probe shift and result collection.
module arp_cache_chain #(
  parameter int ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  arp_pkg::cache_ctl_t ctl,
  output arp_pkg::cache_sts_t sts
);
  localparam int CW = $clog2(ENTRIES + 2);

  arp_pkg::probe_t           probe [ENTRIES+1];
  logic                      free  [ENTRIES+1];
  logic                      hit   [ENTRIES];
  logic [arp_pkg::MAC_W-1:0] mac   [ENTRIES];
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      any_hit;
  logic [arp_pkg::MAC_W-1:0] hit_mac;

  assign probe[0].act = ctl.start;
  assign probe[0].key = ctl.key;
  assign free[0] = 1'b0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    arp_cache_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .probe_in (probe[g]),
      .probe_out(probe[g+1]),
      .free_in  (free[g]),
      .free_out (free[g+1]),
      .clear_hit(ctl.start),
      .wr       (ctl.wr),
      .wr_new   (ctl.wr_new),
      .wr_mac   (ctl.wr_mac),
      .wr_ip    (ctl.key),
      .hit      (hit[g]),
      .mac      (mac[g])
    );
  end

  // at most one cell holds a given address, so an OR collects the hit
  always_comb begin
    any_hit = 1'b0;
    hit_mac = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit[i]) begin
        any_hit = 1'b1;
        hit_mac = hit_mac | mac[i];
      end
    end
  end

  // count probe travel time
  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      if (cnt_r == CW'(ENTRIES)) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign sts.done     = busy_r && cnt_r == CW'(ENTRIES);
  assign sts.hit      = any_hit;
  assign sts.mac      = hit_mac;
  assign sts.has_free = free[ENTRIES];

  chk_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |=> !busy_r)
    else $error("cache scan did not finish");
endmodule

@@ rtl/arp_pend_chain.sv @@
// Row of pending cells; the youngest matching entry ripples out the end.
module arp_pend_chain #(
  parameter int ENTRIES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  arp_pkg::pend_ctl_t ctl,
  output arp_pkg::pend_sts_t sts
);
  localparam int CW = $clog2(ENTRIES + 2);

  arp_pkg::probe_t           probe    [ENTRIES+1];
  logic                      free     [ENTRIES+1];
  logic                      best     [ENTRIES+1];
  logic [arp_pkg::AGE_W-1:0] best_age [ENTRIES+1];
  logic [arp_pkg::TAG_W-1:0] best_tag [ENTRIES+1];
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;

  assign probe[0].act = ctl.start;
  assign probe[0].key = ctl.key;
  assign free[0]      = 1'b0;
  assign best[0]      = 1'b0;
  assign best_age[0]  = '0;
  assign best_tag[0]  = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    arp_pend_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .probe_in    (probe[g]),
      .probe_out   (probe[g+1]),
      .clear_hit   (ctl.start),
      .best_in     (best[g]),
      .best_age_in (best_age[g]),
      .best_tag_in (best_tag[g]),
      .best_out    (best[g+1]),
      .best_age_out(best_age[g+1]),
      .best_tag_out(best_tag[g+1]),
      .free_in     (free[g]),
      .free_out    (free[g+1]),
      .ins         (ctl.ins),
      .ins_ip      (ctl.key),
      .ins_tag     (ctl.ins_tag),
      .rel         (ctl.rel),
      .rel_age     (best_age[ENTRIES])
    );
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      if (cnt_r == CW'(ENTRIES)) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign sts.done     = busy_r && cnt_r == CW'(ENTRIES);
  assign sts.found    = best[ENTRIES];
  assign sts.tag      = best_tag[ENTRIES];
  assign sts.has_free = free[ENTRIES];

  chk_rel_found: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rel |-> best[ENTRIES])
    else $error("release without a matching entry");
endmodule

@@ rtl/arp_cache_responder.sv @@
// ARP offload: resolve commands and received ARP packets come in on one
// channel, results (answers, requests to send, replies, status) go out on
// another, each input ending with a result marked last. One item is handled
// at a time. A resolve sends a probe along the cache cell row; a packet that
// inserts then scans the pending row, and rescans it after each released
// request. Configuration writes are taken at any time.
module arp_cache_responder #(
  parameter int CACHE_ENTRIES   = 16,
  parameter int PENDING_ENTRIES = 8
) (
  input logic      clk,
  input logic      rst_n,
  arp_in_if.sink   in_ch,
  arp_out_if.source out_ch,
  arp_cfg_if.sink  cfg_ch
);
  arp_pkg::state_t   state_r, state_nxt;
  arp_pkg::item_t    item_r;
  arp_pkg::result_t  res_r, res_nxt;
  arp_pkg::result_t  out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [arp_pkg::MAC_W-1:0] own_mac_r;
  logic [arp_pkg::IP_W-1:0]  own_ip_r;
  logic [arp_pkg::MAC_W-1:0] ins_mac_r, ins_mac_nxt;
  logic [arp_pkg::TAG_W-1:0] ans_tag_r, ans_tag_nxt;
  logic                      ins_any_r, ins_any_nxt;
  logic                      rel_pend_r, rel_pend_nxt;

  arp_pkg::cache_ctl_t cctl;
  arp_pkg::cache_sts_t csts;
  arp_pkg::pend_ctl_t  pctl;
  arp_pkg::pend_sts_t  psts;

  logic        in_fire;
  logic        out_free;
  logic [10:0] need_len;
  logic        len_bad;
  logic        type_bad;
  logic        is_bcast;
  logic        is_mine;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // 8 + 2*hlen + 2*plen stays below 1029, so 11 bits hold it
  logic [10:0] sum_w;
  assign sum_w = {2'b0, item_r.hw_len, 1'b0} + {2'b0, item_r.proto_len, 1'b0};
  assign need_len = sum_w + arp_pkg::MIN_BODY;
  assign len_bad  = item_r.body_len < arp_pkg::MIN_BODY || item_r.body_len < need_len;
  assign type_bad = item_r.hw_type != arp_pkg::HTYPE_ETH ||
                    item_r.proto_type != arp_pkg::PTYPE_IPV4;
  assign is_bcast = item_r.dst == arp_pkg::BCAST_MAC;
  assign is_mine  = item_r.dst == own_mac_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r <= '0;
      own_ip_r  <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        arp_pkg::CFG_OWN_MAC:  own_mac_r <= cfg_ch.data;
        arp_pkg::CFG_OWN_IPV4: own_ip_r  <= cfg_ch.data[arp_pkg::IP_W-1:0];
        default: ;
      endcase
    end
  end

  // capture input word
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.cmd         <= {1'b0, in_ch.cmd};
      item_r.dst         <= in_ch.eth_dst_mac;
      item_r.src         <= in_ch.eth_src_mac;
      item_r.body_len    <= in_ch.body_len;
      item_r.hw_type     <= in_ch.hw_type;
      item_r.proto_type  <= in_ch.proto_type;
      item_r.hw_len      <= in_ch.hw_len;
      item_r.proto_len   <= in_ch.proto_len;
      item_r.oper_or_tag <= in_ch.oper_or_tag;
      item_r.sender_mac  <= in_ch.sender_mac;
      item_r.sender_ip   <= in_ch.sender_ip;
      item_r.target_ip   <= in_ch.target_ip;
    end
  end

  assign in_ch.ready = state_r == arp_pkg::S_IDLE;

  // key for both rows: resolve address or sender address
  logic [arp_pkg::IP_W-1:0] key;
  assign key = item_r.cmd[0] ? item_r.sender_ip : item_r.target_ip;

  // next state and sequencing; res_r holds the newest word until it is
  // known whether another word follows it
  always_comb begin
    state_nxt     = state_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    ins_mac_nxt   = ins_mac_r;
    ans_tag_nxt   = ans_tag_r;
    ins_any_nxt   = ins_any_r;
    rel_pend_nxt  = 1'b0;
    cctl          = '0;
    cctl.key      = key;
    cctl.wr_mac   = ins_mac_r;
    pctl          = '0;
    pctl.key      = key;
    pctl.ins_tag  = item_r.oper_or_tag;

    unique case (state_r)
      arp_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = arp_pkg::S_DECIDE;
        end
      end
      arp_pkg::S_DECIDE: begin
        ins_any_nxt = 1'b0;
        if (!item_r.cmd[0]) begin
          cctl.start = 1'b1;
          state_nxt  = arp_pkg::S_CSCAN;
        end else if (len_bad || type_bad) begin
          res_nxt   = '{kind: arp_pkg::KIND_NONE,
                        status: len_bad ? arp_pkg::ST_BAD_LEN : arp_pkg::ST_BAD_TYPE,
                        peer_mac: '0, peer_ip: '0, req_tag: '0, last: 1'b1};
          state_nxt = arp_pkg::S_EMIT_FINAL;
        end else if (is_bcast && item_r.target_ip == own_ip_r) begin
          ins_mac_nxt = item_r.src;
          ins_any_nxt = 1'b1;
          res_nxt   = '{kind: arp_pkg::KIND_REPLY, status: arp_pkg::ST_OK,
                        peer_mac: item_r.src, peer_ip: item_r.sender_ip,
                        req_tag: '0, last: 1'b0};
          cctl.start = 1'b1;
          state_nxt  = arp_pkg::S_CSCAN;
        end else if (!is_bcast && is_mine && item_r.oper_or_tag == arp_pkg::OPER_REPLY) begin
          ins_mac_nxt = item_r.sender_mac;
          cctl.start  = 1'b1;
          state_nxt   = arp_pkg::S_CSCAN;
        end else if (!is_bcast && is_mine && item_r.oper_or_tag != arp_pkg::OPER_REQ) begin
          res_nxt   = '{kind: arp_pkg::KIND_NONE, status: arp_pkg::ST_BAD_OPER,
                        peer_mac: '0, peer_ip: '0, req_tag: '0, last: 1'b1};
          state_nxt = arp_pkg::S_EMIT_FINAL;
        end else begin
          res_nxt   = '{kind: arp_pkg::KIND_NONE, status: arp_pkg::ST_OK,
                        peer_mac: '0, peer_ip: '0, req_tag: '0, last: 1'b1};
          state_nxt = arp_pkg::S_EMIT_FINAL;
        end
      end
      arp_pkg::S_CSCAN: begin
        if (csts.done) begin
          if (!item_r.cmd[0]) begin
            if (csts.hit) begin
              res_nxt   = '{kind: arp_pkg::KIND_ANSWER, status: arp_pkg::ST_OK,
                            peer_mac: csts.mac, peer_ip: item_r.target_ip,
                            req_tag: item_r.oper_or_tag, last: 1'b1};
              state_nxt = arp_pkg::S_EMIT_FINAL;
            end else if (psts.has_free) begin
              pctl.ins  = 1'b1;
              res_nxt   = '{kind: arp_pkg::KIND_REQUEST, status: arp_pkg::ST_OK,
                            peer_mac: arp_pkg::BCAST_MAC, peer_ip: item_r.target_ip,
                            req_tag: '0, last: 1'b1};
              state_nxt = arp_pkg::S_EMIT_FINAL;
            end else begin
              res_nxt   = '{kind: arp_pkg::KIND_NONE, status: arp_pkg::ST_FULL,
                            peer_mac: '0, peer_ip: '0, req_tag: '0, last: 1'b1};
              state_nxt = arp_pkg::S_EMIT_FINAL;
            end
          end else if (csts.hit || csts.has_free) begin
            cctl.wr     = 1'b1;
            cctl.wr_new = !csts.hit;
            pctl.start  = 1'b1;
            state_nxt   = arp_pkg::S_PSCAN;
          end else if (ins_any_r) begin
            // send the held reply first, then the full status
            state_nxt = arp_pkg::S_EMIT_REPLY;
          end else begin
            res_nxt   = '{kind: arp_pkg::KIND_NONE, status: arp_pkg::ST_FULL,
                          peer_mac: '0, peer_ip: '0, req_tag: '0, last: 1'b1};
            state_nxt = arp_pkg::S_EMIT_FINAL;
          end
        end
      end
      arp_pkg::S_EMIT_REPLY: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          res_nxt   = '{kind: arp_pkg::KIND_NONE, status: arp_pkg::ST_FULL,
                        peer_mac: '0, peer_ip: '0, req_tag: '0, last: 1'b1};
          state_nxt = arp_pkg::S_EMIT_FINAL;
        end
      end
      arp_pkg::S_PSCAN: begin
        if (psts.done) begin
          if (psts.found) begin
            ans_tag_nxt  = psts.tag;
            rel_pend_nxt = 1'b1;
            state_nxt    = arp_pkg::S_EMIT_ANSWER;
          end else if (ins_any_r) begin
            // no more answers: the held word closes this input
            res_nxt      = res_r;
            res_nxt.last = 1'b1;
            state_nxt    = arp_pkg::S_EMIT_FINAL;
          end else begin
            res_nxt   = '{kind: arp_pkg::KIND_NONE, status: arp_pkg::ST_OK,
                          peer_mac: '0, peer_ip: '0, req_tag: '0, last: 1'b1};
            state_nxt = arp_pkg::S_EMIT_FINAL;
          end
        end
      end
      arp_pkg::S_EMIT_ANSWER: begin
        // release the entry while its age is still on the chain outputs
        if (rel_pend_r) begin
          pctl.rel = 1'b1;
        end else if (out_free || !ins_any_r) begin
          if (ins_any_r) begin
            out_nxt       = res_r;
            out_valid_nxt = 1'b1;
          end
          res_nxt     = '{kind: arp_pkg::KIND_ANSWER, status: arp_pkg::ST_OK,
                          peer_mac: ins_mac_r, peer_ip: item_r.sender_ip,
                          req_tag: ans_tag_r, last: 1'b0};
          ins_any_nxt = 1'b1;
          pctl.start  = 1'b1;
          state_nxt   = arp_pkg::S_PSCAN;
        end
      end
      arp_pkg::S_EMIT_FINAL: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = arp_pkg::S_IDLE;
        end
      end
      default: state_nxt = arp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= arp_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      ins_any_r   <= 1'b0;
      rel_pend_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ins_any_r   <= ins_any_nxt;
      rel_pend_r  <= rel_pend_nxt;
    end
  end

  // held word, output word and insert data
  always_ff @(posedge clk) begin
    res_r     <= res_nxt;
    out_r     <= out_nxt;
    ins_mac_r <= ins_mac_nxt;
    ans_tag_r <= ans_tag_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.kind     = out_r.kind;
  assign out_ch.status   = out_r.status;
  assign out_ch.peer_mac = out_r.peer_mac;
  assign out_ch.peer_ip  = out_r.peer_ip;
  assign out_ch.req_tag  = out_r.req_tag;
  assign out_ch.last     = out_r.last;

  arp_cache_chain #(.ENTRIES(CACHE_ENTRIES)) u_cache (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (cctl),
    .sts  (csts)
  );

  arp_pend_chain #(.ENTRIES(PENDING_ENTRIES)) u_pend (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (pctl),
    .sts  (psts)
  );

  chk_fire_decide: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == arp_pkg::S_DECIDE)
    else $error("input word not taken into decode");
  chk_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_r))
    else $error("result dropped or changed while stalled");
  chk_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == arp_pkg::S_EMIT_FINAL && out_free |=> state_r == arp_pkg::S_IDLE)
    else $error("final word did not end the item");
endmodule
